// ----- rtl/core/pcg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared types and constants of the projective correspondence gate: packed
// triple layout, fixed-point formats, register indexes and pipeline depth.
// ----------------------------------------------------------------------------
package pcg_pkg;

    // packed triple: x in 15:0, y in 31:16, z in 47:32
    localparam int LANE_W   = 16;
    localparam int LANES    = 3;
    localparam int TRIPLE_W = LANE_W * LANES;

    // rotation entries and normals are Q1.14
    localparam int FRAC_W = 14;

    // configuration write port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_ROW_0   = 3'd0,
        CFG_ROT_ROW_1   = 3'd1,
        CFG_ROT_ROW_2   = 3'd2,
        CFG_TRANSLATION = 3'd3,
        CFG_DIST_LIMIT  = 3'd4,
        CFG_COS_LIMIT   = 3'd5
    } t_cfg_idx;

    // register reset values: identity rotation, no translation
    localparam logic [TRIPLE_W-1:0] ROT_ROW_0_RST   = 48'h0000_0000_4000;
    localparam logic [TRIPLE_W-1:0] ROT_ROW_1_RST   = 48'h0000_4000_0000;
    localparam logic [TRIPLE_W-1:0] ROT_ROW_2_RST   = 48'h4000_0000_0000;
    localparam logic [TRIPLE_W-1:0] TRANSLATION_RST = 48'h0000_0000_0000;
    localparam logic [31:0]         DIST_LIMIT_RST  = 32'd262144;
    localparam logic [15:0]         COS_LIMIT_RST   = 16'd14189;

    // 1.0 in Q.28, compared against ten times a squared length (squared length above 0.1)
    localparam logic [28:0] LEN_SQ_TENTH_Q28 = 29'h1000_0000;

    // register stages between input and output beat
    localparam int NSTG = 6;

    // one signed lane of a packed triple
    function automatic logic signed [LANE_W-1:0] lane_of(
        input logic [TRIPLE_W-1:0] v,
        input int unsigned         k
    );
        lane_of = $signed(v[LANE_W*k +: LANE_W]);
    endfunction

endpackage

// ----- rtl/core/projective_correspondence_gate_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projective_correspondence_gate_core
// Per pixel, moves the current point and normal by the configured rigid
// transform and accepts or rejects the pair against a distance limit and a
// normal angle limit; a pair with the top bit of either index set is rejected.
// ----------------------------------------------------------------------------
//  channel   | direction | beat carries
//  ----------+-----------+-----------------------------------------------------
//  s_axis    | in        | ref/cur index, ref/cur point, ref/cur normal, tlast
//  m_axis    | out       | is_match, matched_ref, matched_cur, tlast
//  cfg       | in        | register index and write data, always ready
//
//  one beat in and one beat out per cycle while m_axis_tready does not stall,
//  through the registered stages (multiply, rotate-sum, difference, square, sum, compare/output)
//  each stage holds its own valid bit and loads whenever the next one frees,
//  so bubbles close up under a stall and nothing is dropped or repeated
//  synchronous active-low reset clears valid bits and registers to identity
// ----------------------------------------------------------------------------
module projective_correspondence_gate_core
    import pcg_pkg::*;
#(
    parameter int INDEX_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // ref_index, cur_index, ref_point, ref_normal, cur_point, cur_normal, zero pad
    input  logic [((2 * (INDEX_BITS + 1) + 4 * TRIPLE_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // frame_end
    input  logic                  s_axis_tlast,

    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // is_match, matched_ref, matched_cur, zero pad
    output logic [((2 * INDEX_BITS + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // frame_end_out
    output logic                  m_axis_tlast,

    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W   = INDEX_BITS + 1;
    localparam int OUT_RAW = 2 * INDEX_BITS + 1;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    // field offsets in the input beat
    localparam int OFS_RIDX = 0;
    localparam int OFS_CIDX = OFS_RIDX + IDX_W;
    localparam int OFS_RPT  = OFS_CIDX + IDX_W;
    localparam int OFS_RNRM = OFS_RPT + TRIPLE_W;
    localparam int OFS_CPT  = OFS_RNRM + TRIPLE_W;
    localparam int OFS_CNRM = OFS_CPT + TRIPLE_W;

    // arithmetic widths
    localparam int PROD_W = 2 * LANE_W;         // lane by lane product
    localparam int ACC_W  = PROD_W + 2;         // sum of three products
    localparam int ROT_W  = ACC_W - FRAC_W;     // rounded rotated lane
    localparam int DIF_W  = ROT_W + 2;          // plus translation, minus ref
    localparam int DSQ_W  = 2 * DIF_W - 1;
    localparam int CSQ_W  = 2 * ROT_W - 1;
    localparam int RSQ_W  = 2 * LANE_W - 1;
    localparam int DOT_W  = ROT_W + LANE_W;
    localparam int DSS_W  = DSQ_W + 2;
    localparam int CSS_W  = CSQ_W + 2;
    localparam int RSS_W  = RSQ_W + 2;
    localparam int DTS_W  = DOT_W + 2;
    localparam int C10_W  = CSS_W + 4;
    localparam int R10_W  = RSS_W + 4;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [TRIPLE_W-1:0] r_rot [LANES];
    logic [TRIPLE_W-1:0] r_trans;
    logic [31:0]         r_dist_lim;
    logic [15:0]         r_cos_lim;

    assign o_cfg_ready = 1'b1;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]   <= ROT_ROW_0_RST;
            r_rot[1]   <= ROT_ROW_1_RST;
            r_rot[2]   <= ROT_ROW_2_RST;
            r_trans    <= TRANSLATION_RST;
            r_dist_lim <= DIST_LIMIT_RST;
            r_cos_lim  <= COS_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROT_ROW_0:   r_rot[0]   <= i_cfg_data;
                CFG_ROT_ROW_1:   r_rot[1]   <= i_cfg_data;
                CFG_ROT_ROW_2:   r_rot[2]   <= i_cfg_data;
                CFG_TRANSLATION: r_trans    <= i_cfg_data;
                CFG_DIST_LIMIT:  r_dist_lim <= i_cfg_data[31:0];
                CFG_COS_LIMIT:   r_cos_lim  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage valid bits and per-stage ready chain
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;

    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign s_axis_tready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input field split
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]    w_ridx;
    logic [IDX_W-1:0]    w_cidx;
    logic [TRIPLE_W-1:0] w_rpt;
    logic [TRIPLE_W-1:0] w_rnrm;
    logic [TRIPLE_W-1:0] w_cpt;
    logic [TRIPLE_W-1:0] w_cnrm;

    assign w_ridx = s_axis_tdata[OFS_RIDX +: IDX_W];
    assign w_cidx = s_axis_tdata[OFS_CIDX +: IDX_W];
    assign w_rpt  = s_axis_tdata[OFS_RPT  +: TRIPLE_W];
    assign w_rnrm = s_axis_tdata[OFS_RNRM +: TRIPLE_W];
    assign w_cpt  = s_axis_tdata[OFS_CPT  +: TRIPLE_W];
    assign w_cnrm = s_axis_tdata[OFS_CNRM +: TRIPLE_W];

    // side payload carried along every stage
    typedef struct packed {
        logic                  pair_ok;
        logic [INDEX_BITS-1:0] ridx;
        logic [INDEX_BITS-1:0] cidx;
        logic                  last;
    } t_side;

    t_side r_side [NSTG-1];

    // ------------------------------------------------------------------
    // stage 1: rotation products for point and normal
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] r1_pp [LANES][LANES];
    logic signed [PROD_W-1:0] r1_pn [LANES][LANES];
    logic [TRIPLE_W-1:0]      r1_rpt;
    logic [TRIPLE_W-1:0]      r1_rnrm;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int i = 0; i < LANES; i++) begin
                for (int j = 0; j < LANES; j++) begin
                    r1_pp[i][j] <= lane_of(r_rot[i], j) * lane_of(w_cpt, j);
                    r1_pn[i][j] <= lane_of(r_rot[i], j) * lane_of(w_cnrm, j);
                end
            end
            r1_rpt           <= w_rpt;
            r1_rnrm          <= w_rnrm;
            r_side[0].pair_ok <= !w_ridx[IDX_W-1] && !w_cidx[IDX_W-1];
            r_side[0].ridx   <= w_ridx[INDEX_BITS-1:0];
            r_side[0].cidx   <= w_cidx[INDEX_BITS-1:0];
            r_side[0].last   <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: sum of products, round half up, drop 14 fraction bits
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] w2_sp [LANES];
    logic signed [ACC_W-1:0] w2_sn [LANES];
    logic signed [ROT_W-1:0] r2_rp [LANES];
    logic signed [ROT_W-1:0] r2_cn [LANES];
    logic [TRIPLE_W-1:0]     r2_rpt;
    logic [TRIPLE_W-1:0]     r2_rnrm;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w2_sp[i] = ACC_W'(r1_pp[i][0]) + ACC_W'(r1_pp[i][1]) + ACC_W'(r1_pp[i][2])
                     + ACC_W'(1 << (FRAC_W - 1));
            w2_sn[i] = ACC_W'(r1_pn[i][0]) + ACC_W'(r1_pn[i][1]) + ACC_W'(r1_pn[i][2])
                     + ACC_W'(1 << (FRAC_W - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            for (int i = 0; i < LANES; i++) begin
                r2_rp[i] <= w2_sp[i][ACC_W-1:FRAC_W];
                r2_cn[i] <= w2_sn[i][ACC_W-1:FRAC_W];
            end
            r2_rpt    <= r1_rpt;
            r2_rnrm   <= r1_rnrm;
            r_side[1] <= r_side[0];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: translate and take the difference to the reference point
    // ------------------------------------------------------------------
    logic signed [DIF_W-1:0] r3_d  [LANES];
    logic signed [ROT_W-1:0] r3_cn [LANES];
    logic [TRIPLE_W-1:0]     r3_rnrm;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            for (int i = 0; i < LANES; i++) begin
                r3_d[i]  <= DIF_W'(r2_rp[i]) + DIF_W'(lane_of(r_trans, i))
                          - DIF_W'(lane_of(r2_rpt, i));
                r3_cn[i] <= r2_cn[i];
            end
            r3_rnrm   <= r2_rnrm;
            r_side[2] <= r_side[1];
        end
    end

    // ------------------------------------------------------------------
    // stage 4: squares and normal products
    // ------------------------------------------------------------------
    logic signed [2*DIF_W-1:0]  w4_dsq [LANES];
    logic signed [2*ROT_W-1:0]  w4_csq [LANES];
    logic signed [2*LANE_W-1:0] w4_rsq [LANES];
    logic [DSQ_W-1:0]           r4_dsq [LANES];
    logic [CSQ_W-1:0]           r4_csq [LANES];
    logic [RSQ_W-1:0]           r4_rsq [LANES];
    logic signed [DOT_W-1:0]    r4_dot [LANES];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w4_dsq[i] = r3_d[i] * r3_d[i];
            w4_csq[i] = r3_cn[i] * r3_cn[i];
            w4_rsq[i] = lane_of(r3_rnrm, i) * lane_of(r3_rnrm, i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            for (int i = 0; i < LANES; i++) begin
                r4_dsq[i] <= w4_dsq[i][DSQ_W-1:0];
                r4_csq[i] <= w4_csq[i][CSQ_W-1:0];
                r4_rsq[i] <= w4_rsq[i][RSQ_W-1:0];
                r4_dot[i] <= DOT_W'(r3_cn[i]) * DOT_W'(lane_of(r3_rnrm, i));
            end
            r_side[3] <= r_side[2];
        end
    end

    // ------------------------------------------------------------------
    // stage 5: sums over the three lanes
    // ------------------------------------------------------------------
    logic [DSS_W-1:0]        r5_dsq;
    logic [CSS_W-1:0]        r5_csq;
    logic [RSS_W-1:0]        r5_rsq;
    logic signed [DTS_W-1:0] r5_dot;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r5_dsq    <= DSS_W'(r4_dsq[0]) + DSS_W'(r4_dsq[1]) + DSS_W'(r4_dsq[2]);
            r5_csq    <= CSS_W'(r4_csq[0]) + CSS_W'(r4_csq[1]) + CSS_W'(r4_csq[2]);
            r5_rsq    <= RSS_W'(r4_rsq[0]) + RSS_W'(r4_rsq[1]) + RSS_W'(r4_rsq[2]);
            r5_dot    <= DTS_W'(r4_dot[0]) + DTS_W'(r4_dot[1]) + DTS_W'(r4_dot[2]);
            r_side[4] <= r_side[3];
        end
    end

    // ------------------------------------------------------------------
    // stage 6: limit tests and output register
    // ------------------------------------------------------------------
    logic [C10_W-1:0]        w_csq10;
    logic [R10_W-1:0]        w_rsq10;
    logic signed [DTS_W-1:0] w_cos_q28;
    logic                    w_dist_ok;
    logic                    w_angle_bad;
    logic                    n_match;

    logic                    r_match;
    logic [INDEX_BITS-1:0]   r_mref;
    logic [INDEX_BITS-1:0]   r_mcur;
    logic                    r_last;

    always_comb begin
        // ten times the squared lengths, as shift and add
        w_csq10     = {r5_csq, 3'b000} + C10_W'({r5_csq, 1'b0});
        w_rsq10     = {r5_rsq, 3'b000} + R10_W'({r5_rsq, 1'b0});
        w_cos_q28   = DTS_W'($signed({r_cos_lim, {FRAC_W{1'b0}}}));
        w_dist_ok   = r5_dsq <= DSS_W'(r_dist_lim);
        w_angle_bad = (w_csq10 > C10_W'(LEN_SQ_TENTH_Q28))
                   && (w_rsq10 > R10_W'(LEN_SQ_TENTH_Q28))
                   && (r5_dot < w_cos_q28);
        n_match     = r_side[4].pair_ok && w_dist_ok && !w_angle_bad;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_match <= n_match;
            r_mref  <= n_match ? r_side[4].ridx : '0;
            r_mcur  <= n_match ? r_side[4].cidx : '0;
            r_last  <= r_side[4].last;
        end
    end

    // output beat
    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = OUT_W'({r_mcur, r_mref, r_match});
    assign m_axis_tlast  = r_last;

endmodule
